// File: hw/rtl/bth_pkg.sv
`timescale 1ns / 1ps

package bth_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CAP_W = 7;
  localparam int HELD_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_REPLACED  = 2'd1;
  localparam logic [1:0] STAT_DISCARDED = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic signed [15:0] score;
    logic signed [15:0] pair;
    logic [31:0]        tag;
  } hit_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] new_score;
    logic signed [15:0] new_pair_score;
    logic [31:0]        new_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_score;
    logic signed [15:0] out_pair_score;
    logic [31:0]        out_tag;
    logic [HELD_W-1:0]  entries_held;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DECIDE,
    S_LOAD_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DOWN_RD,
    S_DOWN_CMP,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START_UP,
    OP_START_REPL,
    OP_REPORT,
    OP_EXTRACT,
    OP_LOAD_LAST,
    OP_UP_STEP,
    OP_DOWN_STEP,
    OP_PUT
  } dp_op_t;

  typedef enum logic [1:0] {
    RD_ROOT,
    RD_PARENT,
    RD_CHILD,
    RD_LAST
  } rd_sel_t;

  typedef struct packed {
    logic       accept;
    logic       set_status;
    logic [1:0] status;
    dp_op_t     op;
    rd_sel_t    rd_sel;
    logic       out_load;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       last_one;
    logic       root_below_new;
    logic       at_root;
    logic       up_move;
    logic       down_move;
  } sts_t;

  function automatic logic ranks_below(hit_t a, hit_t b);
    return (a.score < b.score) || ((a.score == b.score) && (a.pair > b.pair));
  endfunction

endpackage

// File: hw/rtl/bth_ctrl.sv
`timescale 1ns / 1ps

module bth_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  bth_pkg::sts_t sts,
  output bth_pkg::ctl_t ctl
);
  import bth_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctl.accept     = 1'b0;
    ctl.set_status = 1'b0;
    ctl.status     = STAT_INSERTED;
    ctl.op         = OP_NONE;
    ctl.rd_sel     = RD_ROOT;
    ctl.out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ctl.rd_sel = RD_ROOT;
        if (sts.cmd == CMD_INSERT && !sts.full) begin
          ctl.op         = OP_START_UP;
          ctl.set_status = 1'b1;
          ctl.status     = STAT_INSERTED;
          state_nxt      = S_UP_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.set_status = 1'b1;
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.root_below_new) begin
              ctl.op     = OP_START_REPL;
              ctl.status = STAT_REPLACED;
              state_nxt  = S_DOWN_RD;
            end else begin
              ctl.status = STAT_DISCARDED;
              state_nxt  = S_FINISH;
            end
          end
          CMD_EXTRACT: begin
            if (sts.empty) begin
              ctl.status = STAT_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              ctl.status = STAT_INSERTED;
              ctl.op     = OP_EXTRACT;
              ctl.rd_sel = RD_LAST;
              state_nxt  = sts.last_one ? S_FINISH : S_LOAD_LAST;
            end
          end
          default: begin
            if (sts.empty) begin
              ctl.status = STAT_EMPTY;
            end else begin
              ctl.status = STAT_INSERTED;
              ctl.op     = OP_REPORT;
            end
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_LOAD_LAST: begin
        ctl.op    = OP_LOAD_LAST;
        state_nxt = S_DOWN_RD;
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          ctl.op    = OP_PUT;
          state_nxt = S_FINISH;
        end else begin
          ctl.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move) begin
          ctl.op    = OP_UP_STEP;
          state_nxt = S_UP_RD;
        end else begin
          ctl.op    = OP_PUT;
          state_nxt = S_FINISH;
        end
      end
      S_DOWN_RD: begin
        ctl.rd_sel = RD_CHILD;
        state_nxt  = S_DOWN_CMP;
      end
      S_DOWN_CMP: begin
        if (sts.down_move) begin
          ctl.op    = OP_DOWN_STEP;
          state_nxt = S_DOWN_RD;
        end else begin
          ctl.op    = OP_PUT;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ctl.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != S_IDLE);

endmodule

// File: hw/rtl/bth_datapath.sv
`timescale 1ns / 1ps

module bth_datapath #(
  parameter int MAX_ENTRIES = bth_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bth_pkg::CAP_W-1:0]        cfg_data,
  input  bth_pkg::in_word_t                in_word,
  input  bth_pkg::ctl_t                    ctl,
  output bth_pkg::sts_t                    sts,
  output bth_pkg::out_word_t               out_word
);
  import bth_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  hit_t mem [MAX_ENTRIES];

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    pos_r;
  logic [1:0]       cmd_r;
  logic [1:0]       status_r;
  hit_t             new_r;
  hit_t             h_r;
  hit_t             rep_r;
  hit_t             rda_r;
  hit_t             rdb_r;
  out_word_t        res_r;

  logic [AW-1:0] rd_a, rd_b, wr_a;
  logic          we;
  hit_t          wd;
  logic [EW-1:0] cap_eff, cnt_x;
  logic [CW-1:0] pos_m1, parent, parent_m1, cnt_m1;
  logic [CW:0]   lpos, rpos, lpos_m1, child_pos;
  logic          lv, rv, sel_l, sel_r;
  hit_t          best;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  always_comb begin
    cap_eff = EW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = EW'(1);
    end
    if (cap_eff > EW'(MAX_ENTRIES)) begin
      cap_eff = EW'(MAX_ENTRIES);
    end
  end

  assign cnt_x     = EW'(count_r);
  assign pos_m1    = pos_r - 1'b1;
  assign parent    = pos_r >> 1;
  assign parent_m1 = parent - 1'b1;
  assign cnt_m1    = count_r - 1'b1;
  assign lpos      = {pos_r, 1'b0};
  assign rpos      = lpos + 1'b1;
  assign lpos_m1   = lpos - 1'b1;
  assign lv        = (lpos <= {1'b0, count_r});
  assign rv        = (rpos <= {1'b0, count_r});

  always_comb begin
    best  = h_r;
    sel_l = 1'b0;
    sel_r = 1'b0;
    if (lv && ranks_below(rda_r, best)) begin
      best  = rda_r;
      sel_l = 1'b1;
    end
    if (rv && ranks_below(rdb_r, best)) begin
      best  = rdb_r;
      sel_r = 1'b1;
    end
  end

  assign child_pos = sel_r ? rpos : lpos;

  always_comb begin
    rd_a = '0;
    rd_b = '0;
    case (ctl.rd_sel)
      RD_ROOT:   rd_a = '0;
      RD_PARENT: rd_a = parent_m1[AW-1:0];
      RD_CHILD: begin
        rd_a = lpos_m1[AW-1:0];
        rd_b = lpos[AW-1:0];
      end
      RD_LAST:   rd_a = cnt_m1[AW-1:0];
      default:   rd_a = '0;
    endcase
  end

  always_comb begin
    we   = 1'b0;
    wr_a = pos_m1[AW-1:0];
    wd   = h_r;
    case (ctl.op)
      OP_UP_STEP: begin
        we = 1'b1;
        wd = rda_r;
      end
      OP_DOWN_STEP: begin
        we = 1'b1;
        wd = best;
      end
      OP_PUT: begin
        we = 1'b1;
        wd = h_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_a] <= wd;
    end
    rda_r <= mem[rd_a];
    rdb_r <= mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.op == OP_START_UP) begin
      count_r <= count_r + 1'b1;
    end else if (ctl.op == OP_EXTRACT) begin
      count_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= in_word.command;
      new_r <= '{score: in_word.new_score, pair: in_word.new_pair_score,
                 tag: in_word.new_tag};
      rep_r <= '0;
    end
    if (ctl.set_status) begin
      status_r <= ctl.status;
    end
    case (ctl.op)
      OP_START_UP: begin
        h_r   <= new_r;
        pos_r <= count_r + 1'b1;
      end
      OP_START_REPL: begin
        h_r   <= new_r;
        pos_r <= CW'(1);
      end
      OP_REPORT: begin
        rep_r <= rda_r;
      end
      OP_EXTRACT: begin
        rep_r <= rda_r;
      end
      OP_LOAD_LAST: begin
        h_r   <= rda_r;
        pos_r <= CW'(1);
      end
      OP_UP_STEP: begin
        pos_r <= parent;
      end
      OP_DOWN_STEP: begin
        pos_r <= child_pos[CW-1:0];
      end
      default: begin
      end
    endcase
    if (ctl.out_load) begin
      res_r.status         <= status_r;
      res_r.out_score      <= rep_r.score;
      res_r.out_pair_score <= rep_r.pair;
      res_r.out_tag        <= rep_r.tag;
      res_r.entries_held   <= cnt_x[HELD_W-1:0];
    end
  end

  assign sts.cmd            = cmd_r;
  assign sts.full           = (cnt_x >= cap_eff);
  assign sts.empty          = (count_r == '0);
  assign sts.last_one       = (count_r == CW'(1));
  assign sts.root_below_new = ranks_below(rda_r, new_r);
  assign sts.at_root        = (pos_r == CW'(1));
  assign sts.up_move        = ranks_below(h_r, rda_r);
  assign sts.down_move      = sel_l | sel_r;

  assign out_word = res_r;

endmodule

// File: hw/rtl/bounded_top_k_score_heap.sv
`timescale 1ns / 1ps
// Keeps the best hits seen so far in a bounded binary min-heap, worst hit at the root.
// Input words carry a command (insert, extract minimum, peek minimum) and the hit to insert.
// Each accepted word yields exactly one result word with a status, the reported root
// (zero unless extracted or peeked) and the number of entries held afterwards.
// A word is accepted when in_valid is high and in_stall is low; results leave when
// out_valid is high and out_stall is low. cfg_we writes the capacity in use; the user must
// write it only while idle, as the block itself does not enforce this. One word is handled
// at a time. Each level that an insert climbs, or that an extract or a replacing insert sifts
// down, takes a heap memory read state and a compare-and-write state.
// While a result waits under out_stall the next word is still accepted and processed;
// it holds in its final step until the output register is free.
// Synchronous reset empties the heap, drops any pending result and sets the capacity
// to 64; the heap memory itself is not cleared.

module bounded_top_k_score_heap #(
  parameter int MAX_ENTRIES = bth_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bth_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bth_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bth_pkg::out_word_t         out_word
);
  import bth_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  bth_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .ctl      (ctl),
    .sts      (sts),
    .out_word (out_word)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is still in progress");

  a_empty_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STAT_EMPTY) |->
      (out_word.out_score == 16'sd0 && out_word.out_pair_score == 16'sd0 &&
       out_word.out_tag == 32'd0 && out_word.entries_held == '0))
    else $error("empty result carries data or a non-zero count");

  a_full_path_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == STAT_REPLACED ||
                   out_word.status == STAT_DISCARDED)) |->
      (out_word.entries_held != '0))
    else $error("replace or discard reported with an empty heap");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("pending result overwritten");

endmodule
